@@ hdl/ata_pio_sector_reader_assert.svh @@
// Assertion macros shared by the sector reader modules.
`ifndef ATA_PIO_SECTOR_READER_ASSERT_SVH
`define ATA_PIO_SECTOR_READER_ASSERT_SVH

// Check that a property holds on every clock edge outside reset.
`define ATA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never occurs outside reset.
`define ATA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ hdl/ata_rd_pkg.sv @@
// Shared types, constants and result builders for the ATA PIO sector reader.
package ata_rd_pkg;

  localparam int unsigned MAX_SECTORS      = 256;
  localparam int unsigned WORDS_PER_SECTOR = 256;
  localparam int unsigned RES_MAX          = 7;

  localparam logic [23:0] POLL_LIMIT_RST = 24'h100000;

  // Result kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  // Input opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_REPLY = 1'b1;

  // Task-file registers
  localparam logic [2:0] REG_DATA    = 3'd0;
  localparam logic [2:0] REG_COUNT   = 3'd2;
  localparam logic [2:0] REG_LBA_LO  = 3'd3;
  localparam logic [2:0] REG_LBA_MID = 3'd4;
  localparam logic [2:0] REG_LBA_HI  = 3'd5;
  localparam logic [2:0] REG_SELECT  = 3'd6;
  localparam logic [2:0] REG_STATUS  = 3'd7;

  // Status bits and command bytes
  localparam int unsigned ST_BSY_BIT = 7;
  localparam int unsigned ST_DRQ_BIT = 3;
  localparam int unsigned ST_ERR_BIT = 0;
  localparam logic [7:0]  CMD_READ_SECTORS = 8'h20;
  localparam logic [7:0]  SEL_LBA_MASTER   = 8'hE0;

  typedef struct packed {
    logic        opcode;
    logic [27:0] start_lba;
    logic [8:0]  sector_count;
    logic [15:0] read_value;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  reg_index;
    logic [7:0]  write_value;
    logic [15:0] data_word;
    logic        success;
  } res_t;

  typedef struct packed {
    res_t [RES_MAX-1:0] list;
    logic [2:0]         count;
  } res_list_t;

  function automatic res_t res_wr(logic [2:0] reg_idx, logic [7:0] value);
    res_t r;
    r             = '0;
    r.kind        = KIND_WRITE;
    r.reg_index   = reg_idx;
    r.write_value = value;
    return r;
  endfunction

  function automatic res_t res_rd(logic [2:0] reg_idx);
    res_t r;
    r           = '0;
    r.kind      = KIND_READ;
    r.reg_index = reg_idx;
    return r;
  endfunction

  function automatic res_t res_data(logic [15:0] word);
    res_t r;
    r           = '0;
    r.kind      = KIND_DATA;
    r.data_word = word;
    return r;
  endfunction

  function automatic res_t res_fin(logic ok);
    res_t r;
    r         = '0;
    r.kind    = KIND_DONE;
    r.success = ok;
    return r;
  endfunction

endpackage

@@ hdl/ata_rd_if.sv @@
// Valid/ready channel interfaces for sector reader items and results.
interface ata_rd_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [27:0] start_lba;
  logic [8:0]  sector_count;
  logic [15:0] read_value;

  modport source (output valid, opcode, start_lba, sector_count, read_value, input ready);
  modport sink   (input valid, opcode, start_lba, sector_count, read_value, output ready);
endinterface

interface ata_rd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  reg_index;
  logic [7:0]  write_value;
  logic [15:0] data_word;
  logic        success;
  logic        last;

  modport source (output valid, kind, reg_index, write_value, data_word, success, last,
                  input ready);
  modport sink   (input valid, kind, reg_index, write_value, data_word, success, last,
                  output ready);
endinterface

@@ hdl/ata_rd_seq.sv @@
// Read sequencer: holds the protocol state and builds the result list of one item.
`include "ata_pio_sector_reader_assert.svh"

module ata_rd_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  ata_rd_pkg::item_t     item_i,
  input  logic [23:0]           poll_limit_i,
  output ata_rd_pkg::res_list_t res_o
);
  import ata_rd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BSY1,
    PH_DRQ,
    PH_DATA,
    PH_BSY2,
    PH_FINAL
  } phase_e;

  phase_e      phase_q, phase_d, wait_ph;
  logic [23:0] polls_q, polls_d;
  logic [27:0] lba_q, lba_d;
  logic [8:0]  total_q, total_d;
  logic [8:0]  sectors_q, sectors_d;
  logic [7:0]  words_q, words_d;
  logic        do_wait, do_poll;
  logic [7:0]  st;
  logic [8:0]  words_inc;
  res_list_t   res;

  assign st        = item_i.read_value[7:0];
  assign words_inc = {1'b0, words_q} + 9'd1;

  // Work out next state and the results of the current item
  always_comb begin
    phase_d   = phase_q;
    polls_d   = polls_q;
    lba_d     = lba_q;
    total_d   = total_q;
    sectors_d = sectors_q;
    words_d   = words_q;
    do_wait   = 1'b0;
    do_poll   = 1'b0;
    wait_ph   = PH_DRQ;
    res       = '0;

    if (item_i.opcode == OP_START) begin
      lba_d     = item_i.start_lba;
      total_d   = item_i.sector_count;
      sectors_d = '0;
      words_d   = '0;
      if (item_i.sector_count == '0 ||
          item_i.sector_count > 9'(MAX_SECTORS)) begin
        phase_d          = PH_IDLE;
        res.list[res.count] = res_fin(1'b0);
        res.count        = res.count + 3'd1;
      end else begin
        do_wait = 1'b1;
        wait_ph = PH_BSY1;
      end
    end else begin
      unique case (phase_q)
        PH_BSY1: begin
          if (st[ST_BSY_BIT]) begin
            do_poll = 1'b1;
          end else begin
            res.list[0] = res_wr(REG_LBA_LO, lba_q[7:0]);
            res.list[1] = res_wr(REG_LBA_MID, lba_q[15:8]);
            res.list[2] = res_wr(REG_LBA_HI, lba_q[23:16]);
            res.list[3] = res_wr(REG_SELECT, SEL_LBA_MASTER | {4'd0, lba_q[27:24]});
            res.list[4] = res_wr(REG_COUNT, total_q[7:0]);
            res.list[5] = res_wr(REG_STATUS, CMD_READ_SECTORS);
            res.count   = 3'd6;
            do_wait     = 1'b1;
            wait_ph     = PH_DRQ;
          end
        end
        PH_DRQ: begin
          if (st[ST_ERR_BIT]) begin
            phase_d     = PH_IDLE;
            res.list[0] = res_fin(1'b0);
            res.count   = 3'd1;
          end else if (st[ST_DRQ_BIT]) begin
            phase_d     = PH_DATA;
            words_d     = '0;
            res.list[0] = res_rd(REG_DATA);
            res.count   = 3'd1;
          end else begin
            do_poll = 1'b1;
          end
        end
        PH_DATA: begin
          res.list[0] = res_data(item_i.read_value);
          res.count   = 3'd1;
          if (words_inc >= 9'(WORDS_PER_SECTOR)) begin
            words_d   = '0;
            sectors_d = sectors_q + 9'd1;
            do_wait   = 1'b1;
            wait_ph   = (sectors_d >= total_q) ? PH_BSY2 : PH_DRQ;
          end else begin
            words_d     = words_inc[7:0];
            res.list[1] = res_rd(REG_DATA);
            res.count   = 3'd2;
          end
        end
        PH_BSY2: begin
          if (st[ST_BSY_BIT]) begin
            do_poll = 1'b1;
          end else begin
            phase_d     = PH_FINAL;
            res.list[0] = res_rd(REG_STATUS);
            res.count   = 3'd1;
          end
        end
        PH_FINAL: begin
          phase_d     = PH_IDLE;
          res.list[0] = res_fin(!st[ST_ERR_BIT]);
          res.count   = 3'd1;
        end
        default: begin
          // Drop replies that arrive while idle
        end
      endcase
    end

    // Start a status wait with a fresh poll budget, or fail at once if the budget is zero
    if (do_wait) begin
      polls_d = poll_limit_i;
      if (poll_limit_i == '0) begin
        phase_d             = PH_IDLE;
        res.list[res.count] = res_fin(1'b0);
      end else begin
        phase_d             = wait_ph;
        res.list[res.count] = res_rd(REG_STATUS);
      end
      res.count = res.count + 3'd1;
    end

    // Spend one poll and ask again, or time out
    if (do_poll) begin
      polls_d = polls_q - 24'd1;
      if (polls_d == '0) begin
        phase_d     = PH_IDLE;
        res.list[0] = res_fin(1'b0);
      end else begin
        res.list[0] = res_rd(REG_STATUS);
      end
      res.count = 3'd1;
    end
  end

  assign res_o = res;

  // Hold sequencer state, advance on each consumed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      polls_q   <= '0;
      lba_q     <= '0;
      total_q   <= '0;
      sectors_q <= '0;
      words_q   <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      polls_q   <= polls_d;
      lba_q     <= lba_d;
      total_q   <= total_d;
      sectors_q <= sectors_d;
      words_q   <= words_d;
    end
  end

  // A consumed item that ends in a finish leaves the sequencer idle
  `ATA_ASSERT(a_fin_goes_idle, step_i && res.count != '0 && res.list[res.count - 3'd1].kind == KIND_DONE |=> phase_q == PH_IDLE, "finish did not return to idle")
  // Data words are only produced while a sector transfer runs
  `ATA_ASSERT(a_data_in_phase, step_i && res.count != '0 && res.list[0].kind == KIND_DATA |-> phase_q == PH_DATA, "data word outside data phase")
  // Outside a wait no poll budget is spent
  `ATA_ASSERT_NEVER(a_poll_idle, step_i && do_poll && phase_q == PH_IDLE, "poll spent while idle")

endmodule

@@ hdl/ata_pio_sector_reader.sv @@
// Top level of the ATA LBA28 PIO sector reader: item register, sequencer, result buffer.
//
//   channel   dir   handshake     payload
//   in_i      in    valid/ready   opcode, start_lba, sector_count, read_value
//   out_i     out   valid/ready   kind, reg_index, write_value, data_word, success, last
//   cfg       in    cfg_we_i      cfg_wdata_i -> poll_limit
//
// An item is registered on acceptance and consumed by the sequencer once the buffer is free,
// which writes its whole result list (up to seven results) into the result buffer.
// The buffer drains one result per cycle while out_i.ready is high; an item giving one
// result flows at one item per cycle under the same condition.
// The item register takes a new item while the buffer still holds results.
// Reset is asynchronous and active low; poll_limit resets to 0x100000.
`include "ata_pio_sector_reader_assert.svh"

module ata_pio_sector_reader (
  input  logic          clk_i,
  input  logic          rst_ni,
  ata_rd_in_if.sink     in_i,
  ata_rd_out_if.source  out_i,
  input  logic          cfg_we_i,
  input  logic [23:0]   cfg_wdata_i
);
  import ata_rd_pkg::*;

  logic                     in_vld_q;
  item_t                    in_q;
  logic                     step;
  logic [23:0]              poll_limit_q;
  res_list_t                seq_res;
  res_t [RES_MAX-1:0]       res_q;
  logic [2:0]               res_cnt_q;
  logic [2:0]               res_idx_q;
  logic [2:0]               res_idx_inc;
  logic                     out_vld;
  logic                     out_fire;
  logic                     out_last;
  logic                     buf_free;
  res_t                     cur;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit_q <= POLL_LIMIT_RST;
    end else if (cfg_we_i) begin
      poll_limit_q <= cfg_wdata_i;
    end
  end

  // Result buffer handshake
  assign out_vld     = (res_cnt_q != '0);
  assign res_idx_inc = res_idx_q + 3'd1;
  assign out_last    = (res_idx_inc == res_cnt_q);
  assign out_fire    = out_vld && out_i.ready;
  assign buf_free    = !out_vld || (out_fire && out_last);
  assign step        = in_vld_q && buf_free;
  assign in_i.ready  = !in_vld_q || step;

  // Item register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q.opcode       <= in_i.opcode;
      in_q.start_lba    <= in_i.start_lba;
      in_q.sector_count <= in_i.sector_count;
      in_q.read_value   <= in_i.read_value;
    end
  end

  ata_rd_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .item_i       (in_q),
    .poll_limit_i (poll_limit_q),
    .res_o        (seq_res)
  );

  // Load the result list on a step, advance on each taken result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cnt_q <= '0;
      res_idx_q <= '0;
    end else if (step) begin
      res_cnt_q <= seq_res.count;
      res_idx_q <= '0;
    end else if (out_fire && out_last) begin
      res_cnt_q <= '0;
      res_idx_q <= '0;
    end else if (out_fire) begin
      res_idx_q <= res_idx_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= seq_res.list;
    end
  end

  // Present the current result
  assign cur               = res_q[res_idx_q];
  assign out_i.valid       = out_vld;
  assign out_i.kind        = cur.kind;
  assign out_i.reg_index   = cur.reg_index;
  assign out_i.write_value = cur.write_value;
  assign out_i.data_word   = cur.data_word;
  assign out_i.success     = cur.success;
  assign out_i.last        = out_last;

  // The read pointer stays inside the loaded list
  `ATA_ASSERT(a_idx_in_list, out_vld |-> res_idx_q < res_cnt_q, "result pointer past list end")
  // A finish result always closes its item's results
  `ATA_ASSERT(a_done_is_last, out_vld && cur.kind == KIND_DONE |-> out_last, "finish not marked last")
  // A waiting item is held until the sequencer consumes it
  `ATA_ASSERT(a_item_held, in_vld_q && !step |=> in_vld_q && $stable(in_q), "pending item lost")

endmodule
